// ===== rtl/ftpo_pkg.sv =====
// ftpo_pkg: types and constants shared by the feedback oscillator voice.
// No dependencies.
package ftpo_pkg;

   localparam int unsigned NUM_REGS = 7;
   localparam logic [2:0] REG_COARSE  = 3'd0;
   localparam logic [2:0] REG_REL_TWO = 3'd1;
   localparam logic [2:0] REG_REL_THR = 3'd2;
   localparam logic [2:0] REG_FBK_ONE = 3'd3;
   localparam logic [2:0] REG_FBK_TWO = 3'd4;
   localparam logic [2:0] REG_FBK_THR = 3'd5;
   localparam logic [2:0] REG_RATE    = 3'd6;

   localparam logic [24:0] C4_Q16 = 25'd17145895;

   function automatic logic [31:0] root_const(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd0:  r = 32'd1518500250;
         4'd1:  r = 32'd1276901417;
         4'd2:  r = 32'd1170923762;
         4'd3:  r = 32'd1121280436;
         4'd4:  r = 32'd1097253708;
         4'd5:  r = 32'd1085434106;
         4'd6:  r = 32'd1079572136;
         4'd7:  r = 32'd1076653033;
         4'd8:  r = 32'd1075196443;
         4'd9:  r = 32'd1074468888;
         4'd10: r = 32'd1074105294;
         4'd11: r = 32'd1073923544;
         default: r = 32'd1073741824;
      endcase
      return r;
   endfunction

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_LOAD  = 10'b0000000010,
      ST_POW   = 10'b0000000100,
      ST_MULC  = 10'b0000001000,
      ST_DIV   = 10'b0000010000,
      ST_PHASE = 10'b0000100000,
      ST_CUB1  = 10'b0001000000,
      ST_CUB2  = 10'b0010000000,
      ST_ACC   = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

endpackage

// ===== rtl/ftpo_ram.sv =====
// ftpo_ram: generic simple dual-port RAM (one write, one read port) with registered read.
// No dependencies.
module ftpo_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/feedback_triple_phase_oscillator_core.sv =====
// feedback_triple_phase_oscillator_core: three feedback oscillators per voice.
// Uses ftpo_pkg and ftpo_ram.
//
//  channel | direction | payload
//  req_    | in        | tdata = channel[3:0], pitch_cv[20:4]
//  rsp_    | out       | tdata = out_channel[3:0], audio[20:4]
//  csr_    | in        | index[2:0], data[17:0]
//
// After reset a clearing pass over the CHANNELS*OSCILLATORS phase words zeroes
// the state memories; no beat is taken meanwhile. After a req beat, per
// oscillator: a load, 12 shared-multiplier steps, the C4 product, a 57-step
// restoring divider (one quotient bit per cycle), the phase update, two cubic
// products and accumulation; then the result is registered for rsp_.
// req_tready is low while clearing, an item is in work or its result waits.
module feedback_triple_phase_oscillator_core #(
   parameter int CHANNELS    = 16,
   parameter int OSCILLATORS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // channel[3:0], pitch_cv[20:4]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_channel[3:0], audio[20:4]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_data
);
   localparam int PH_DEPTH = CHANNELS * OSCILLATORS;
   localparam int PAW = (PH_DEPTH > 1) ? $clog2(PH_DEPTH) : 1;
   localparam int FAW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int OW  = (OSCILLATORS > 1) ? $clog2(OSCILLATORS + 1) : 1;

   // configuration
   logic signed [15:0] coarse_ff;
   logic signed [14:0] rel2_ff, rel3_ff;
   logic [16:0] fb1_ff, fb2_ff, fb3_ff;
   logic [17:0] rate_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         coarse_ff <= '0; rel2_ff <= '0; rel3_ff <= '0;
         fb1_ff <= 17'd32768; fb2_ff <= 17'd32768; fb3_ff <= 17'd32768;
         rate_ff <= 18'd48000;
      end else if (csr_valid) begin
         unique case (csr_index)
            ftpo_pkg::REG_COARSE:  coarse_ff <= csr_data[15:0];
            ftpo_pkg::REG_REL_TWO: rel2_ff   <= csr_data[14:0];
            ftpo_pkg::REG_REL_THR: rel3_ff   <= csr_data[14:0];
            ftpo_pkg::REG_FBK_ONE: fb1_ff    <= csr_data[16:0];
            ftpo_pkg::REG_FBK_TWO: fb2_ff    <= csr_data[16:0];
            ftpo_pkg::REG_FBK_THR: fb3_ff    <= csr_data[16:0];
            ftpo_pkg::REG_RATE:    rate_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // state memories
   logic           ph_we, fb_we;
   logic [PAW-1:0] ph_waddr, ph_raddr;
   logic [23:0]    ph_wdata, ph_rdata;
   logic [FAW-1:0] fb_waddr, fb_raddr;
   logic [23:0]    fb_wdata, fb_rdata;

   ftpo_ram #(.WIDTH(24), .DEPTH(PH_DEPTH)) u_phase (
      .clock(clock), .wr_en(ph_we), .wr_addr(ph_waddr), .wr_data(ph_wdata),
      .rd_addr(ph_raddr), .rd_data(ph_rdata));
   ftpo_ram #(.WIDTH(24), .DEPTH(CHANNELS)) u_feed (
      .clock(clock), .wr_en(fb_we), .wr_addr(fb_waddr), .wr_data(fb_wdata),
      .rd_addr(fb_raddr), .rd_data(fb_rdata));

   ftpo_pkg::state_type st_ff;
   logic           clr_ff;
   logic [PAW-1:0] clr_cnt_ff;
   logic [3:0]     ch_ff;
   logic signed [16:0] cv_ff;
   logic [FAW-1:0] slot_ff;
   logic [PAW-1:0] base_ff;
   logic [OW-1:0]  osc_ff;
   logic [11:0]    frac_ff;
   logic signed [8:0] oct_ff;
   logic [3:0]     k_ff;
   logic [31:0]    m_ff;
   logic [56:0]    num_ff;      // dividend shifting out
   logic [56:0]    quo_ff;
   logic [18:0]    rem_ff;
   logic [5:0]     dcnt_ff;
   logic signed [25:0] u_ff;    // tmp (Q.23, signed)
   logic signed [25:0] t3_ff;
   logic signed [49:0] a_ff;
   logic signed [28:0] t2_ff;
   logic signed [49:0] sum_out_ff, sum_loop_ff;
   logic [16:0]    w_ff;
   logic           rsp_v_ff;
   logic [23:0]    rsp_d_ff;

   assign req_tready = !clr_ff && st_ff == ftpo_pkg::ST_IDLE && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   // channel to state slot, a fixed table over the 4-bit channel
   logic [FAW-1:0] slot_in;
   always_comb begin
      slot_in = '0;
      for (int i = 0; i < 16; i++)
         if (req_tdata[3:0] == 4'(i)) slot_in = FAW'(i % CHANNELS);
   end

   // per-oscillator selects
   logic [1:0] sel;
   logic signed [19:0] e_val;
   logic [16:0] w_sel;
   always_comb begin
      sel = (osc_ff == '0) ? 2'd0 : ((osc_ff == OW'(1)) ? 2'd1 : 2'd2);
      e_val = 20'(cv_ff) + 20'(coarse_ff);
      if (sel == 2'd1) e_val = e_val + 20'(rel2_ff);
      if (sel == 2'd2) e_val = e_val + 20'(rel3_ff);
      case (sel)
         2'd0: w_sel = fb1_ff;
         2'd1: w_sel = fb2_ff;
         default: w_sel = fb3_ff;
      endcase
      if (w_sel > 17'd65536) w_sel = 17'd65536;
   end

   // shared multiplier (one product per cycle)
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   always_comb begin
      mul_a = '0; mul_b = '0;
      unique case (st_ff)
         ftpo_pkg::ST_POW:  begin mul_a = 33'(m_ff); mul_b = 33'(ftpo_pkg::root_const(k_ff)); end
         ftpo_pkg::ST_MULC: begin mul_a = 33'(m_ff); mul_b = 33'(ftpo_pkg::C4_Q16); end
         ftpo_pkg::ST_CUB1: begin mul_a = 33'(u_ff); mul_b = 33'(u_ff - 26'sd8388608); end
         ftpo_pkg::ST_CUB2: begin mul_a = 33'(a_ff); mul_b = 33'(t3_ff - 26'sd8388608); end
         ftpo_pkg::ST_ACC:  begin mul_a = 33'(t2_ff); mul_b = 33'(w_ff); end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   // divider step
   logic [17:0] fs;
   logic [19:0] trial;
   assign fs = (rate_ff == '0) ? 18'd1 : rate_ff;
   assign trial = {rem_ff, num_ff[56]} - {2'b0, fs};

   // phase update
   logic [23:0] step;
   logic signed [9:0] sh;
   logic signed [27:0] uu;
   always_comb begin
      sh = 10'(oct_ff) - 10'sd22;
      if (sh >= 0) step = 24'(quo_ff << sh[5:0]);
      else if (sh > -10'sd64) step = 24'(quo_ff >> 6'(-sh));
      else step = '0;
      uu = 28'({1'b0, ph_rdata + step}) + 28'($signed(fb_rdata)) * 28'sd8;
   end

   // final scaling
   logic signed [55:0] aud_x, aud_f;
   logic signed [63:0] loop_x, loop_f;
   assign aud_x  = 56'(sum_out_ff) * 56'sd10;
   assign loop_x = 64'(sum_loop_ff) * 64'sd19661;
   assign aud_f  = aud_x >>> 27;
   assign loop_f = loop_x >>> 35;

   always_comb begin
      ph_raddr = base_ff + PAW'(osc_ff);
      fb_raddr = slot_ff;
      ph_we = 1'b0; ph_waddr = ph_raddr; ph_wdata = ph_rdata + step;
      fb_we = 1'b0; fb_waddr = slot_ff; fb_wdata = '0;
      if (clr_ff) begin
         ph_we = 1'b1; ph_waddr = clr_cnt_ff; ph_wdata = '0;
         fb_we = 1'b1; fb_waddr = FAW'(clr_cnt_ff);
      end else if (st_ff == ftpo_pkg::ST_PHASE) begin
         ph_we = 1'b1;
      end else if (st_ff == ftpo_pkg::ST_DONE) begin
         fb_we = 1'b1;
         if (loop_f > 64'sd8388607) fb_wdata = 24'h7FFFFF;
         else if (loop_f < -64'sd8388608) fb_wdata = 24'h800000;
         else fb_wdata = loop_f[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ftpo_pkg::ST_IDLE;
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + PAW'(1);
            if (32'(clr_cnt_ff) == PH_DEPTH - 1) clr_ff <= 1'b0;
         end
         unique case (st_ff)
            ftpo_pkg::ST_IDLE: if (req_tvalid && req_tready) begin
               ch_ff <= req_tdata[3:0];
               cv_ff <= req_tdata[20:4];
               slot_ff <= slot_in;
               base_ff <= PAW'(32'(slot_in) * OSCILLATORS);
               osc_ff <= '0;
               sum_out_ff <= '0; sum_loop_ff <= '0;
               st_ff <= ftpo_pkg::ST_LOAD;
            end
            ftpo_pkg::ST_LOAD: begin
               frac_ff <= e_val[11:0];
               oct_ff <= 9'(e_val >>> 12);
               w_ff <= w_sel;
               m_ff <= 32'd1073741824;
               k_ff <= '0;
               st_ff <= ftpo_pkg::ST_POW;
            end
            ftpo_pkg::ST_POW: begin
               if (frac_ff[11 - k_ff]) m_ff <= 32'((mul_p[63:0] + 64'd536870912) >> 30);
               k_ff <= k_ff + 4'd1;
               if (k_ff == 4'd11) st_ff <= ftpo_pkg::ST_MULC;
            end
            ftpo_pkg::ST_MULC: begin
               num_ff <= {mul_p[56:0]};
               rem_ff <= '0; dcnt_ff <= '0;
               st_ff <= ftpo_pkg::ST_DIV;
            end
            ftpo_pkg::ST_DIV: begin
               if (!trial[19]) begin
                  rem_ff <= trial[18:0];
                  quo_ff <= {quo_ff[55:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[17:0], num_ff[56]};
                  quo_ff <= {quo_ff[55:0], 1'b0};
               end
               num_ff <= {num_ff[55:0], 1'b0};
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'd56) st_ff <= ftpo_pkg::ST_PHASE;
            end
            ftpo_pkg::ST_PHASE: begin
               // truncating remainders of the phase-plus-feedback sum
               u_ff <= 26'(uu - ((uu / 28'sd8388608) * 28'sd8388608));
               t3_ff <= 26'(uu - ((uu / 28'sd16777216) * 28'sd16777216));
               st_ff <= ftpo_pkg::ST_CUB1;
            end
            ftpo_pkg::ST_CUB1: begin
               a_ff <= 50'(mul_p >>> 23);
               st_ff <= ftpo_pkg::ST_CUB2;
            end
            ftpo_pkg::ST_CUB2: begin
               t2_ff <= 29'(mul_p >>> 23);
               st_ff <= ftpo_pkg::ST_ACC;
            end
            ftpo_pkg::ST_ACC: begin
               sum_loop_ff <= sum_loop_ff + 50'(mul_p);
               sum_out_ff <= sum_out_ff + 50'(t2_ff) * 50'sd65536 - 50'(mul_p);
               if (32'(osc_ff) == OSCILLATORS - 1) st_ff <= ftpo_pkg::ST_DONE;
               else begin
                  osc_ff <= osc_ff + OW'(1);
                  st_ff <= ftpo_pkg::ST_LOAD;
               end
            end
            ftpo_pkg::ST_DONE: begin
               rsp_v_ff <= 1'b1;
               rsp_d_ff[3:0] <= ch_ff;
               if (aud_f > 56'sd49152) rsp_d_ff[20:4] <= 17'sd49152;
               else if (aud_f < -56'sd49152) rsp_d_ff[20:4] <= -17'sd49152;
               else rsp_d_ff[20:4] <= aud_f[16:0];
               rsp_d_ff[23:21] <= '0;
               st_ff <= ftpo_pkg::ST_IDLE;
            end
            default: st_ff <= ftpo_pkg::ST_IDLE;
         endcase
      end
   end
endmodule
